// ===== rtl/core/signed_int_to_decimal_ascii_macros.svh =====
// Assertion macros used by the converter's serializer.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk_i outside reset.
`define SITDAC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sitdac assertion failed");

// Next-cycle implication, checked on the rising edge of clk_i outside reset.
`define SITDAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sitdac assertion failed");

`endif

// ===== rtl/core/sitdac_pkg.sv =====
// Package with the constants of the decimal ASCII converter.
`timescale 1ns / 1ps
package sitdac_pkg;

  localparam int DefValueBits = 32;
  localparam int DabbleStep   = 4;
  localparam int CharW        = 6;
  localparam int DigitW       = 4;

  localparam logic [CharW-1:0] DIGIT_BASE = 6'd48;
  localparam logic [CharW-1:0] MINUS_CHAR = 6'd45;

endpackage

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// Top level of the signed binary to decimal ASCII converter.
`timescale 1ns / 1ps
// Each input transfer carries one signed VALUE_BITS integer; its decimal text leaves as
// one output transfer per character, most significant first, with a leading '-' for
// negative values, no leading zeros, and tlast on the final digit. The pipeline is a
// negation stage, ceil(VALUE_BITS/4) shift-and-add-three stages (eight at 32 bits) and
// a serializer. The serializer sends one character per cycle while the output accepts
// them, and it takes the next number as it sends the final character of the last one,
// while the stages behind it fill.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sitdac_pkg::DefValueBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // value, in the low VALUE_BITS bits
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // character in bits 5:0
  output logic [7:0]                          m_axis_tdata_o,
  output logic                                m_axis_tlast_o
);

  localparam int Step   = sitdac_pkg::DabbleStep;
  localparam int Digits = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int NStg   = (VALUE_BITS + Step - 1) / Step;
  localparam int PadW   = NStg * Step;
  localparam int BcdW   = Digits * 4;

  logic                    st_valid [NStg+1];
  logic                    st_ready [NStg+1];
  logic                    st_neg   [NStg+1];
  logic [BcdW-1:0]         st_bcd   [NStg+1];
  logic [PadW-1:0]         st_mag   [NStg+1];

  logic                    valid0_q;
  logic                    neg0_q;
  logic [PadW-1:0]         mag0_q;
  logic [VALUE_BITS-1:0]   in_val;
  logic                    in_neg;
  logic [VALUE_BITS-1:0]   in_mag;
  logic [sitdac_pkg::CharW-1:0] out_char;

  assign in_val          = s_axis_tdata_i[VALUE_BITS-1:0];
  assign in_neg          = in_val[VALUE_BITS-1];
  assign in_mag          = in_neg ? (~in_val + 1'b1) : in_val;
  assign s_axis_tready_o = !valid0_q || st_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      valid0_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      neg0_q <= in_neg;
      mag0_q <= PadW'(in_mag);
    end
  end

  assign st_valid[0] = valid0_q;
  assign st_neg[0]   = neg0_q;
  assign st_bcd[0]   = '0;
  assign st_mag[0]   = mag0_q;

  for (genvar g = 0; g < NStg; g++) begin : g_stage
    sitdac_dabble_stage #(
      .Digits (Digits),
      .MagW   (PadW),
      .Step   (Step)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (st_valid[g]),
      .in_ready_o  (st_ready[g]),
      .in_neg_i    (st_neg[g]),
      .in_bcd_i    (st_bcd[g]),
      .in_mag_i    (st_mag[g]),
      .out_valid_o (st_valid[g+1]),
      .out_ready_i (st_ready[g+1]),
      .out_neg_o   (st_neg[g+1]),
      .out_bcd_o   (st_bcd[g+1]),
      .out_mag_o   (st_mag[g+1])
    );
  end

  sitdac_serializer #(
    .Digits (Digits)
  ) u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (st_valid[NStg]),
    .in_ready_o  (st_ready[NStg]),
    .in_neg_i    (st_neg[NStg]),
    .in_bcd_i    (st_bcd[NStg]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, out_char};

endmodule

// ===== rtl/core/sitdac_dabble_stage.sv =====
// One pipeline stage of the shift-and-add-three binary to BCD conversion.
`timescale 1ns / 1ps
module sitdac_dabble_stage #(
  parameter int Digits = 10,
  parameter int MagW   = 32,
  parameter int Step   = sitdac_pkg::DabbleStep
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_neg_i,
  input  logic [Digits*4-1:0]  in_bcd_i,
  input  logic [MagW-1:0]      in_mag_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_neg_o,
  output logic [Digits*4-1:0]  out_bcd_o,
  output logic [MagW-1:0]      out_mag_o
);

  logic                valid_q;
  logic                neg_q;
  logic [Digits*4-1:0] bcd_q, bcd_d;
  logic [MagW-1:0]     mag_q, mag_d;

  always_comb begin
    bcd_d = in_bcd_i;
    mag_d = in_mag_i;
    for (int s = 0; s < Step; s++) begin
      for (int d = 0; d < Digits; d++) begin
        if (bcd_d[d*4 +: 4] >= 4'd5) begin
          bcd_d[d*4 +: 4] = bcd_d[d*4 +: 4] + 4'd3;
        end
      end
      {bcd_d, mag_d} = {bcd_d, mag_d} << 1;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      neg_q <= in_neg_i;
      bcd_q <= bcd_d;
      mag_q <= mag_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_neg_o   = neg_q;
  assign out_bcd_o   = bcd_q;
  assign out_mag_o   = mag_q;

endmodule

// ===== rtl/core/sitdac_serializer.sv =====
// Serializer that sends the sign and the significant digits one character per transfer.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_macros.svh"
module sitdac_serializer #(
  parameter int Digits = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             in_neg_i,
  input  logic [Digits*4-1:0]              in_bcd_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sitdac_pkg::CharW-1:0]     out_char_o,
  output logic                             out_last_o
);

  localparam int IdxW = (Digits > 1) ? $clog2(Digits) : 1;

  logic                          busy_q, busy_d;
  logic                          sign_q, sign_d;
  logic [IdxW-1:0]               idx_q, idx_d;
  logic [Digits*4-1:0]           bcd_q;
  logic                          ovalid_q, ovalid_d;
  logic [sitdac_pkg::CharW-1:0]  char_q, char_d;
  logic                          last_q, last_d;
  logic [IdxW-1:0]               lead_idx;
  logic                          out_free;
  logic                          final_char;
  logic                          load;
  logic [sitdac_pkg::DigitW-1:0] cur_digit;

  always_comb begin
    lead_idx = '0;
    for (int k = 0; k < Digits; k++) begin
      if (in_bcd_i[k*4 +: 4] != 4'd0) begin
        lead_idx = IdxW'(k);
      end
    end
  end

  assign out_free   = !ovalid_q || out_ready_i;
  assign final_char = busy_q && !sign_q && (idx_q == '0);
  assign in_ready_o = !busy_q || (out_free && final_char);
  assign load       = in_valid_i && in_ready_o;
  assign cur_digit  = bcd_q[idx_q*4 +: 4];

  always_comb begin
    busy_d   = busy_q;
    sign_d   = sign_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    char_d   = char_q;
    last_d   = last_q;
    if (out_free) begin
      ovalid_d = busy_q;
      last_d   = final_char;
      if (sign_q) begin
        char_d = sitdac_pkg::MINUS_CHAR;
      end else begin
        char_d = sitdac_pkg::DIGIT_BASE + sitdac_pkg::CharW'(cur_digit);
      end
      if (busy_q) begin
        if (sign_q) begin
          sign_d = 1'b0;
        end else if (idx_q == '0) begin
          busy_d = 1'b0;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
    end
    if (load) begin
      busy_d = 1'b1;
      sign_d = in_neg_i;
      idx_d  = lead_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      sign_q   <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      sign_q   <= sign_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    if (load) begin
      bcd_q <= in_bcd_i;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  `SITDAC_ASSERT_NOW(a_sign_only_busy, sign_q, busy_q)
  `SITDAC_ASSERT_NEXT(a_final_flagged, out_free && final_char, ovalid_q && last_q)
  `SITDAC_ASSERT_NEXT(a_sign_first, load && in_neg_i, sign_q && busy_q)
  `SITDAC_ASSERT_NOW(a_char_range, ovalid_q,
    char_q == sitdac_pkg::MINUS_CHAR || (char_q >= sitdac_pkg::DIGIT_BASE && char_q <= 6'd57))

endmodule
